FILE: hdl/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

  // Field and register widths.
  localparam int ELAPSED_WIDTH = 16;
  localparam int GAIN_W        = 16;
  localparam int SERVO_W       = 15;
  localparam int LIMIT_W       = 30;
  localparam int HEAD_W        = 16;
  localparam int RATE_W        = 19;
  localparam int CFG_W         = 30;
  localparam int CFG_IDX_W     = 3;

  // Internal widths. The integral holds the clamp limit plus one step's addition.
  localparam int ADD_W     = ELAPSED_WIDTH + HEAD_W;
  localparam int INTEG_W   = ((ADD_W > 31) ? ADD_W : 31) + 2;
  localparam int ISUM_W    = INTEG_W + 1;
  localparam int FILT_W    = 27;
  localparam int FSCALE_W  = FILT_W + 8;
  localparam int WRAP_W    = 18;
  localparam int MUL_A_W   = (INTEG_W > 30) ? INTEG_W : 30;
  localparam int MUL_B_W   = (ELAPSED_WIDTH + 1 > 31) ? ELAPSED_WIDTH + 1 : 31;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = INTEG_W + 27;
  localparam int SHIFTED_W = ACC_W - 16;
  localparam int QSAT_W    = 28;
  localparam int U_W       = 29;
  localparam int U_SUM_W   = U_W + 1;
  localparam int QUOT_W    = 20;
  localparam int CORR_W    = 19;
  localparam int STEER_W   = 22;
  localparam int RECIP_SHIFT = 39;

  // Heading wrap constants.
  localparam logic signed [WRAP_W-1:0] WRAP_HALF = 18'sd18000;
  localparam logic signed [WRAP_W-1:0] WRAP_FULL = 18'sd36000;

  // Rounding bias of the correction, half of 65536000.
  localparam logic [25:0] ROUND_BIAS = 26'd32768000;

  // The shifted sum is saturated to 28 bits, then offset to stay positive
  // for the divide by 1000. The offset is a multiple of 1000.
  localparam logic signed [QSAT_W-1:0] QSAT_MAX    = 28'sh7FFFFFF;
  localparam logic signed [QSAT_W-1:0] QSAT_MIN    = 28'sh8000000;
  localparam logic [U_W-1:0]           DIV_OFFSET  = 29'd134218000;
  localparam logic [QUOT_W-1:0]        QUOT_OFFSET = 20'd134218;
  localparam logic [29:0]              RECIP_1000  = 30'd549755813;
  localparam logic [U_SUM_W-1:0]       DIVISOR     = 30'd1000;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd512;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd0;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd0;
  localparam logic [SERVO_W-1:0] SLEW_STEP_RST    = 15'd250;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST  = 30'd30000000;
  localparam logic [SERVO_W-1:0] SERVO_CENTER_RST = 15'd7100;
  localparam logic [SERVO_W-1:0] SERVO_LOW_RST    = 15'd100;
  localparam logic [SERVO_W-1:0] SERVO_HIGH_RST   = 15'd15000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_SLEW_STEP,
    REG_INTEG_LIMIT,
    REG_SERVO_CENTER,
    REG_SERVO_LOW,
    REG_SERVO_HIGH
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [SERVO_W-1:0] slew_step;
    logic [LIMIT_W-1:0] integ_limit;
    logic [SERVO_W-1:0] servo_center;
    logic [SERVO_W-1:0] servo_low;
    logic [SERVO_W-1:0] servo_high;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILTER,
    ST_INTEG,
    ST_PROP,
    ST_DERIV,
    ST_SCALE,
    ST_ITERM,
    ST_ROUND,
    ST_SAT,
    ST_RECIP,
    ST_QUOT,
    ST_CORR,
    ST_STEER,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_ELAPSED,
    MUL_PROP,
    MUL_DERIV,
    MUL_INTEG,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_X1000,
    ACC_ADD,
    ACC_ROUND
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     filt_en;
    logic     integ_en;
    acc_op_t  acc_op;
    logic     sat_en;
    logic     quot_en;
    logic     corr_en;
    logic     steer_en;
    logic     update_en;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: hdl/hps_cfg_regs.sv
`timescale 1ns / 1ps

module hps_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hps_pkg::CFG_W-1:0]    cfg_data,
  output hps_pkg::cfg_t                cfg
);
  import hps_pkg::*;

  // Register file, written one register at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= PROP_GAIN_RST;
      cfg.integ_gain   <= INTEG_GAIN_RST;
      cfg.deriv_gain   <= DERIV_GAIN_RST;
      cfg.slew_step    <= SLEW_STEP_RST;
      cfg.integ_limit  <= INTEG_LIMIT_RST;
      cfg.servo_center <= SERVO_CENTER_RST;
      cfg.servo_low    <= SERVO_LOW_RST;
      cfg.servo_high   <= SERVO_HIGH_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[GAIN_W-1:0];
        REG_SLEW_STEP:    cfg.slew_step    <= cfg_data[SERVO_W-1:0];
        REG_INTEG_LIMIT:  cfg.integ_limit  <= cfg_data[LIMIT_W-1:0];
        REG_SERVO_CENTER: cfg.servo_center <= cfg_data[SERVO_W-1:0];
        REG_SERVO_LOW:    cfg.servo_low    <= cfg_data[SERVO_W-1:0];
        REG_SERVO_HIGH:   cfg.servo_high   <= cfg_data[SERVO_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/hps_ctrl.sv
`timescale 1ns / 1ps

module hps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             sample_fresh,
  input  hps_pkg::status_t status,
  output logic             in_stall,
  output hps_pkg::cmd_t    cmd
);
  import hps_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a stale sample goes straight to the result.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sample_fresh ? ST_FILTER : ST_EMIT;
        end
      end
      ST_FILTER: state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_PROP;
      ST_PROP:   state_next = ST_DERIV;
      ST_DERIV:  state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ITERM;
      ST_ITERM:  state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_SAT;
      ST_SAT:    state_next = ST_RECIP;
      ST_RECIP:  state_next = ST_QUOT;
      ST_QUOT:   state_next = ST_CORR;
      ST_CORR:   state_next = ST_STEER;
      ST_STEER:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands for each state.
  always_comb begin
    in_stall    = (state != ST_IDLE);
    cmd         = '0;
    cmd.mul_sel = MUL_ELAPSED;
    cmd.acc_op  = ACC_HOLD;
    case (state)
      ST_IDLE: cmd.capture = in_valid;
      ST_FILTER: begin
        cmd.filt_en = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ELAPSED;
      end
      ST_INTEG: begin
        cmd.integ_en = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_PROP;
      end
      ST_PROP: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DERIV;
      end
      ST_DERIV: begin
        cmd.acc_op  = ACC_SUB;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INTEG;
      end
      ST_SCALE:  cmd.acc_op = ACC_X1000;
      ST_ITERM:  cmd.acc_op = ACC_ADD;
      ST_ROUND:  cmd.acc_op = ACC_ROUND;
      ST_SAT:    cmd.sat_en = 1'b1;
      ST_RECIP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RECIP;
      end
      ST_QUOT:   cmd.quot_en   = 1'b1;
      ST_CORR:   cmd.corr_en   = 1'b1;
      ST_STEER:  cmd.steer_en  = 1'b1;
      ST_UPDATE: cmd.update_en = 1'b1;
      ST_EMIT:   cmd.emit      = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/hps_datapath.sv
`timescale 1ns / 1ps

module hps_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  hps_pkg::cmd_t                           cmd,
  input  hps_pkg::cfg_t                           cfg,
  input  logic signed [hps_pkg::HEAD_W-1:0]       target_heading,
  input  logic signed [hps_pkg::HEAD_W-1:0]       measured_heading,
  input  logic signed [hps_pkg::RATE_W-1:0]       yaw_rate,
  input  logic [hps_pkg::ELAPSED_WIDTH-1:0]       elapsed_ms,
  input  logic                                    restart,
  input  logic                                    out_stall,
  output hps_pkg::status_t                        status,
  output logic                                    out_valid,
  output logic [hps_pkg::SERVO_W-1:0]             servo_command,
  output logic signed [hps_pkg::HEAD_W-1:0]       heading_error,
  output logic                                    at_limit
);
  import hps_pkg::*;

  // Controller state.
  logic signed [INTEG_W-1:0] integ;
  logic signed [FILT_W-1:0]  filt;
  logic [SERVO_W-1:0]        last_cmd;

  // Working registers.
  logic signed [HEAD_W-1:0]  err;
  logic [ELAPSED_WIDTH-1:0]  dt;
  logic signed [RATE_W-1:0]  rate;
  logic signed [PROD_W-1:0]  prod;
  logic signed [INTEG_W-1:0] add_step;
  logic signed [ACC_W-1:0]   acc;
  logic [U_W-1:0]            quo_in;
  logic [QUOT_W-1:0]         quo;
  logic signed [CORR_W-1:0]  corr;
  logic [SERVO_W-1:0]        steer_cmd;

  // Combinational values.
  logic signed [WRAP_W-1:0]   wrap_0;
  logic signed [WRAP_W-1:0]   wrap_1;
  logic signed [WRAP_W-1:0]   wrap_2;
  logic signed [FILT_W:0]     filt_diff;
  logic signed [FSCALE_W-1:0] filt_ext;
  logic signed [FSCALE_W-1:0] filt_scaled;
  logic signed [FILT_W-1:0]   filt_next;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ADD_W-1:0]    add_v;
  logic signed [ISUM_W-1:0]   integ_sum;
  logic signed [ISUM_W-1:0]   lim_v;
  logic signed [ISUM_W-1:0]   integ_next;
  logic signed [ACC_W-1:0]    prod_t;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [SHIFTED_W-1:0] shifted;
  logic signed [QSAT_W-1:0]   q_sat;
  logic [U_SUM_W-1:0]         u_sum;
  logic [U_SUM_W-1:0]         q_x1000;
  logic [U_SUM_W-1:0]         rem;
  logic [QUOT_W-1:0]          quo_fix;
  logic signed [QUOT_W:0]     corr_wide;
  logic signed [STEER_W-1:0]  want;
  logic signed [STEER_W-1:0]  slew_v;
  logic signed [STEER_W-1:0]  step_diff;
  logic signed [STEER_W-1:0]  step_d;
  logic signed [STEER_W-1:0]  cmd_raw;
  logic signed [STEER_W-1:0]  lo_v;
  logic signed [STEER_W-1:0]  hi_v;
  logic signed [STEER_W-1:0]  cmd_lo;
  logic signed [STEER_W-1:0]  cmd_hi;
  logic                       steer_at_limit;
  logic                       last_at_limit;
  logic                       out_free;

  // Heading error wrapped into half a turn either way.
  always_comb begin
    wrap_0 = WRAP_W'(target_heading) - WRAP_W'(measured_heading);
    if (wrap_0 > WRAP_HALF) begin
      wrap_1 = wrap_0 - WRAP_FULL;
    end else if (wrap_0 < -WRAP_HALF) begin
      wrap_1 = wrap_0 + WRAP_FULL;
    end else begin
      wrap_1 = wrap_0;
    end
    if (wrap_1 > WRAP_HALF) begin
      wrap_2 = wrap_1 - WRAP_FULL;
    end else if (wrap_1 < -WRAP_HALF) begin
      wrap_2 = wrap_1 + WRAP_FULL;
    end else begin
      wrap_2 = wrap_1;
    end
  end

  // Rate filter: f += floor(90 * ((rate << 8) - f) / 256).
  always_comb begin
    filt_diff   = (FILT_W + 1)'($signed({rate, 8'b0})) - (FILT_W + 1)'(filt);
    filt_ext    = FSCALE_W'(filt_diff);
    filt_scaled = (filt_ext <<< 6) + (filt_ext <<< 4) + (filt_ext <<< 3) + (filt_ext <<< 1);
    filt_next   = filt + filt_scaled[FSCALE_W-1:8];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = MUL_A_W'(err);
    mul_b = MUL_B_W'(dt);
    case (cmd.mul_sel)
      MUL_ELAPSED: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(dt);
      end
      MUL_PROP: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(cfg.prop_gain);
      end
      MUL_DERIV: begin
        mul_a = MUL_A_W'(filt);
        mul_b = MUL_B_W'(cfg.deriv_gain);
      end
      MUL_INTEG: begin
        mul_a = MUL_A_W'(integ);
        mul_b = MUL_B_W'(cfg.integ_gain);
      end
      MUL_RECIP: begin
        mul_a = MUL_A_W'(quo_in);
        mul_b = MUL_B_W'(RECIP_1000);
      end
      default: begin
      end
    endcase
  end

  // Integral step, clamped to the limit.
  always_comb begin
    add_v     = prod[ADD_W-1:0];
    integ_sum = ISUM_W'(integ) + ISUM_W'(add_v);
    lim_v     = ISUM_W'(cfg.integ_limit);
    if (integ_sum > lim_v) begin
      integ_next = lim_v;
    end else if (integ_sum < -lim_v) begin
      integ_next = -lim_v;
    end else begin
      integ_next = integ_sum;
    end
  end

  // Accumulator for 1000 * (256 * P - D) + 256 * I + bias.
  always_comb begin
    prod_t   = prod[ACC_W-1:0];
    acc_next = acc;
    case (cmd.acc_op)
      ACC_HOLD:  acc_next = acc;
      ACC_LOAD:  acc_next = prod_t <<< 8;
      ACC_SUB:   acc_next = acc - prod_t;
      ACC_X1000: acc_next = (acc <<< 10) - (acc <<< 4) - (acc <<< 3);
      ACC_ADD:   acc_next = acc + (prod_t <<< 8);
      ACC_ROUND: acc_next = acc + ACC_W'(ROUND_BIAS);
      default:   acc_next = acc;
    endcase
  end

  // Divide by 65536 and saturate; beyond the saturation point the slew
  // limit gives the same command anyway.
  always_comb begin
    shifted = acc[ACC_W-1:16];
    if (shifted > SHIFTED_W'(QSAT_MAX)) begin
      q_sat = QSAT_MAX;
    end else if (shifted < SHIFTED_W'(QSAT_MIN)) begin
      q_sat = QSAT_MIN;
    end else begin
      q_sat = QSAT_W'(shifted);
    end
    u_sum = U_SUM_W'(q_sat) + U_SUM_W'(DIV_OFFSET);
  end

  // Reciprocal quotient may be one short; one compare fixes it.
  always_comb begin
    q_x1000 = U_SUM_W'({quo, 10'b0}) - U_SUM_W'({quo, 4'b0}) - U_SUM_W'({quo, 3'b0});
    rem     = U_SUM_W'(quo_in) - q_x1000;
    quo_fix = (rem >= DIVISOR) ? quo + QUOT_W'(1) : quo;
    corr_wide = $signed({1'b0, quo_fix}) - $signed({1'b0, QUOT_OFFSET});
  end

  // Slew limit against the last command, then the low and high clamps.
  always_comb begin
    want      = STEER_W'(cfg.servo_center) - STEER_W'(corr);
    slew_v    = STEER_W'(cfg.slew_step);
    step_diff = want - STEER_W'(last_cmd);
    if (step_diff > slew_v) begin
      step_d = slew_v;
    end else if (step_diff < -slew_v) begin
      step_d = -slew_v;
    end else begin
      step_d = step_diff;
    end
    cmd_raw = STEER_W'(last_cmd) + step_d;
    lo_v    = STEER_W'(cfg.servo_low);
    hi_v    = STEER_W'(cfg.servo_high);
    cmd_lo  = (cmd_raw < lo_v) ? lo_v : cmd_raw;
    cmd_hi  = (cmd_lo > hi_v) ? hi_v : cmd_lo;
  end

  // Limit flags against the current servo range.
  assign steer_at_limit = (steer_cmd <= cfg.servo_low) || (steer_cmd >= cfg.servo_high);
  assign last_at_limit  = (last_cmd <= cfg.servo_low) || (last_cmd >= cfg.servo_high);

  // Output register frees up when empty or taken in this cycle.
  assign out_free        = !out_valid || !out_stall;
  assign status.out_free = out_free;

  // Controller state: restart clears it when the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      filt     <= '0;
      last_cmd <= SERVO_CENTER_RST;
    end else begin
      if (cmd.capture && restart) begin
        integ    <= '0;
        filt     <= '0;
        last_cmd <= cfg.servo_center;
      end
      if (cmd.filt_en) begin
        filt <= filt_next;
      end
      if (cmd.integ_en) begin
        integ <= INTEG_W'(integ_next);
      end
      if (cmd.update_en) begin
        last_cmd <= steer_cmd;
        if (steer_at_limit) begin
          integ <= integ - add_step;
        end
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err  <= HEAD_W'(wrap_2);
      dt   <= (elapsed_ms == '0) ? ELAPSED_WIDTH'(1) : elapsed_ms;
      rate <= yaw_rate;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.integ_en) begin
      add_step <= INTEG_W'(add_v);
    end
    acc <= acc_next;
    if (cmd.sat_en) begin
      quo_in <= u_sum[U_W-1:0];
    end
    if (cmd.quot_en) begin
      quo <= prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    end
    if (cmd.corr_en) begin
      corr <= CORR_W'(corr_wide);
    end
    if (cmd.steer_en) begin
      steer_cmd <= cmd_hi[SERVO_W-1:0];
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      servo_command <= last_cmd;
      heading_error <= err;
      at_limit      <= last_at_limit;
    end
  end

endmodule

FILE: hdl/heading_pid_steering_unit.sv
// A fresh sample steps through the filter, integral, term, rounding, divide and
// steering states before its result is posted; a stale sample goes straight to
// the result; an output stall holds it back. A request is taken only when idle,
// as the controller steps one shared multiplier and accumulator through the terms.
// Reset (rst, synchronous, active high) loads the register defaults, clears the
// integral and rate filter, sets the last command to 7100 and empties the output.
`timescale 1ns / 1ps

module heading_pid_steering_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [hps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hps_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hps_pkg::HEAD_W-1:0]    target_heading,
  input  logic signed [hps_pkg::HEAD_W-1:0]    measured_heading,
  input  logic signed [hps_pkg::RATE_W-1:0]    yaw_rate,
  input  logic [hps_pkg::ELAPSED_WIDTH-1:0]    elapsed_ms,
  input  logic                                 sample_fresh,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hps_pkg::SERVO_W-1:0]          servo_command,
  output logic signed [hps_pkg::HEAD_W-1:0]    heading_error,
  output logic                                 at_limit
);
  import hps_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  hps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  hps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .sample_fresh (sample_fresh),
    .status       (status),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // Arithmetic and output register.
  hps_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .yaw_rate         (yaw_rate),
    .elapsed_ms       (elapsed_ms),
    .restart          (restart),
    .out_stall        (out_stall),
    .status           (status),
    .out_valid        (out_valid),
    .servo_command    (servo_command),
    .heading_error    (heading_error),
    .at_limit         (at_limit)
  );

endmodule

FILE: hdl/hps_checker.sv
`timescale 1ns / 1ps

module hps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [hps_pkg::SERVO_W-1:0]       servo_command,
  input logic signed [hps_pkg::HEAD_W-1:0] heading_error,
  input logic                              at_limit
);

  // A taken request keeps the block busy in the following cycle.
  a_busy_after_request: assert property (
    @(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall
  ) else $error("block not busy after a request was taken");

  // Reset empties the output register.
  a_reset_empties: assert property (
    @(posedge clk) rst |=> !out_valid
  ) else $error("result valid right after reset");

  // A stalled result holds.
  a_result_holds: assert property (
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=>
      (out_valid && $stable(servo_command) && $stable(heading_error) && $stable(at_limit))
  ) else $error("stalled result changed or dropped");

  // The block only turns ready again once the result is posted.
  a_ready_with_result: assert property (
    @(posedge clk) disable iff (rst) $fell(in_stall) |-> out_valid
  ) else $error("block ready again without a posted result");

endmodule

bind heading_pid_steering_unit hps_checker u_hps_checker (.*);

FILE: tb/heading_pid_checker.sv
`timescale 1ns / 1ps

module heading_pid_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [hps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hps_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [hps_pkg::HEAD_W-1:0] target_heading,
  input  logic signed [hps_pkg::HEAD_W-1:0] measured_heading,
  input  logic signed [hps_pkg::RATE_W-1:0] yaw_rate,
  input  logic [hps_pkg::ELAPSED_WIDTH-1:0] elapsed_ms,
  input  logic                              sample_fresh,
  input  logic                              restart,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [hps_pkg::SERVO_W-1:0]       servo_command,
  input  logic signed [hps_pkg::HEAD_W-1:0] heading_error,
  input  logic                              at_limit,
  output int                                failures,
  output int                                outstanding
);
  import hps_pkg::*;

  typedef struct packed {
    logic [SERVO_W-1:0] servo_command;
    logic [HEAD_W-1:0]  heading_error;
    logic               at_limit;
  } steer_out_t;

  // Shadow copy of the registers and the controller state.
  cfg_t       regs;
  longint     integ_cdms;
  longint     rate_filt;
  longint     last_cmd;
  steer_out_t expected_cmds[$];
  int         mismatches;

  // Division that rounds toward minus infinity.
  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // One controller step: updates the shadow state and returns the command it yields.
  function automatic steer_out_t predict_steer(
    input logic signed [HEAD_W-1:0] tgt,
    input logic signed [HEAD_W-1:0] meas,
    input logic signed [RATE_W-1:0] rate,
    input logic [ELAPSED_WIDTH-1:0] dt_in,
    input logic                     fresh,
    input logic                     clr
  );
    longint     err, dt, add, num, corr, want, delta, cmd, lo, hi, lim, slew;
    steer_out_t res;
    lo   = longint'(regs.servo_low);
    hi   = longint'(regs.servo_high);
    lim  = longint'(regs.integ_limit);
    slew = longint'(regs.slew_step);

    // Heading error is folded back into half a turn either way.
    err = longint'(tgt) - longint'(meas);
    while (err > 18000) err -= 36000;
    while (err < -18000) err += 36000;

    if (clr) begin
      integ_cdms = 0;
      rate_filt  = 0;
      last_cmd   = longint'(regs.servo_center);
    end

    if (fresh) begin
      dt = (dt_in == '0) ? 1 : longint'(dt_in);
      rate_filt += floor_quot(90 * (longint'(rate) * 256 - rate_filt), 256);

      add        = err * dt;
      integ_cdms = clip(integ_cdms + add, -lim, lim);

      // Q8.8 gains; the integral term is per second, hence the factors of 1000.
      num = longint'(regs.prop_gain) * err * 256000
          + longint'(regs.integ_gain) * integ_cdms * 256
          - longint'(regs.deriv_gain) * rate_filt * 1000;
      corr = floor_quot(num + 64'sd32768000, 65536000);

      // Slew against the last command, then clamp low first and high second.
      want  = longint'(regs.servo_center) - corr;
      delta = clip(want - last_cmd, -slew, slew);
      cmd   = last_cmd + delta;
      if (cmd < lo) cmd = lo;
      if (cmd > hi) cmd = hi;

      // Anti-windup: a command at a limit takes back this step's integration.
      if (cmd <= lo || cmd >= hi) integ_cdms -= add;
      last_cmd = cmd;
    end

    res.servo_command = last_cmd[SERVO_W-1:0];
    res.heading_error = err[HEAD_W-1:0];
    res.at_limit      = (last_cmd <= lo || last_cmd >= hi);
    return res;
  endfunction

  always @(posedge clk) begin : track
    steer_out_t oldest;
    if (rst) begin
      regs.prop_gain    = PROP_GAIN_RST;
      regs.integ_gain   = INTEG_GAIN_RST;
      regs.deriv_gain   = DERIV_GAIN_RST;
      regs.slew_step    = SLEW_STEP_RST;
      regs.integ_limit  = INTEG_LIMIT_RST;
      regs.servo_center = SERVO_CENTER_RST;
      regs.servo_low    = SERVO_LOW_RST;
      regs.servo_high   = SERVO_HIGH_RST;
      integ_cdms        = 0;
      rate_filt         = 0;
      last_cmd          = longint'(SERVO_CENTER_RST);
      mismatches        = 0;
      expected_cmds.delete();
    end else begin
      // Track register writes.
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:    regs.prop_gain    = cfg_data[GAIN_W-1:0];
          REG_INTEG_GAIN:   regs.integ_gain   = cfg_data[GAIN_W-1:0];
          REG_DERIV_GAIN:   regs.deriv_gain   = cfg_data[GAIN_W-1:0];
          REG_SLEW_STEP:    regs.slew_step    = cfg_data[SERVO_W-1:0];
          REG_INTEG_LIMIT:  regs.integ_limit  = cfg_data[LIMIT_W-1:0];
          REG_SERVO_CENTER: regs.servo_center = cfg_data[SERVO_W-1:0];
          REG_SERVO_LOW:    regs.servo_low    = cfg_data[SERVO_W-1:0];
          REG_SERVO_HIGH:   regs.servo_high   = cfg_data[SERVO_W-1:0];
          default: ;
        endcase
      end

      // Compare a delivered result with the oldest expected command.
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, servo_command %0d",
                   $time, servo_command);
        end else begin
          oldest = expected_cmds.pop_front();
          if (servo_command !== oldest.servo_command) begin
            mismatches++;
            $display("%0t: servo_command expected %0d, got %0d",
                     $time, oldest.servo_command, servo_command);
          end
          if (heading_error !== oldest.heading_error) begin
            mismatches++;
            $display("%0t: heading_error expected %0d, got %0d",
                     $time, $signed(oldest.heading_error), heading_error);
          end
          if (at_limit !== oldest.at_limit) begin
            mismatches++;
            $display("%0t: at_limit expected %0b, got %0b",
                     $time, oldest.at_limit, at_limit);
          end
        end
      end

      // Every accepted request yields exactly one result.
      if (in_valid && !in_stall)
        expected_cmds.push_back(predict_steer(target_heading, measured_heading, yaw_rate,
                                              elapsed_ms, sample_fresh, restart));
    end
    failures    <= mismatches;
    outstanding <= expected_cmds.size();
  end

endmodule

FILE: tb/tb_heading_pid_steering_unit.sv
`timescale 1ns / 1ps

module tb_heading_pid_steering_unit;
  import hps_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 200;

  typedef enum int {
    CFG_TYPICAL,
    CFG_ALL_MAX,
    CFG_ALL_ZERO,
    CFG_CROSSED,
    CFG_ANY
  } cfg_style_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [HEAD_W-1:0]  target_heading;
  logic signed [HEAD_W-1:0]  measured_heading;
  logic signed [RATE_W-1:0]  yaw_rate;
  logic [ELAPSED_WIDTH-1:0]  elapsed_ms;
  logic                      sample_fresh;
  logic                      restart;
  logic                      out_valid;
  logic                      out_stall;
  logic [SERVO_W-1:0]        servo_command;
  logic signed [HEAD_W-1:0]  heading_error;
  logic                      at_limit;
  int                        failures;
  int                        outstanding;
  int                        hold_reqs = 0;
  int                        burst_left = 0;
  int                        cycle_count = 0;

  always #4 clk = ~clk;

  heading_pid_steering_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .yaw_rate         (yaw_rate),
    .elapsed_ms       (elapsed_ms),
    .sample_fresh     (sample_fresh),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .servo_command    (servo_command),
    .heading_error    (heading_error),
    .at_limit         (at_limit)
  );

  heading_pid_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .yaw_rate         (yaw_rate),
    .elapsed_ms       (elapsed_ms),
    .sample_fresh     (sample_fresh),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .servo_command    (servo_command),
    .heading_error    (heading_error),
    .at_limit         (at_limit),
    .failures         (failures),
    .outstanding      (outstanding)
  );

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver pacing: short random stalls, free-running stretches, rare long holds,
  // and a long hold whenever the stimulus asks for one.
  initial begin : rx_pacing
    int served;
    int r;
    served = 0;
    out_stall = 1'b0;
    forever begin
      if (hold_reqs != served) begin
        served = hold_reqs;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 1) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(60, 200)) @(negedge clk);
        end else if (r < 8) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 80)) @(negedge clk);
        end else begin
          out_stall <= ($urandom_range(0, 3) == 0);
          @(negedge clk);
        end
      end
    end
  end

  // Offer one request, wait until it is taken, then, outside a burst, idle for a random gap.
  task automatic send_sample(input int tgt, input int meas, input int rate, input int dt,
                             input logic fresh, input logic clr);
    int gap;
    int r;
    in_valid         <= 1'b1;
    target_heading   <= tgt[HEAD_W-1:0];
    measured_heading <= meas[HEAD_W-1:0];
    yaw_rate         <= rate[RATE_W-1:0];
    elapsed_ms       <= dt[ELAPSED_WIDTH-1:0];
    sample_fresh     <= fresh;
    restart          <= clr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(20, 80);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stop offering and wait until every expected result has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all registers while the block is idle.
  task automatic load_config(input cfg_t c);
    cfg_reg_t idx;
    drain();
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_write <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_PROP_GAIN:    cfg_data <= CFG_W'(c.prop_gain);
        REG_INTEG_GAIN:   cfg_data <= CFG_W'(c.integ_gain);
        REG_DERIV_GAIN:   cfg_data <= CFG_W'(c.deriv_gain);
        REG_SLEW_STEP:    cfg_data <= CFG_W'(c.slew_step);
        REG_INTEG_LIMIT:  cfg_data <= CFG_W'(c.integ_limit);
        REG_SERVO_CENTER: cfg_data <= CFG_W'(c.servo_center);
        REG_SERVO_LOW:    cfg_data <= CFG_W'(c.servo_low);
        REG_SERVO_HIGH:   cfg_data <= CFG_W'(c.servo_high);
        default: ;
      endcase
      @(negedge clk);
      idx = idx.next();
    end
    cfg_write <= 1'b0;
  endtask

  function automatic cfg_t make_config(input cfg_style_t style);
    cfg_t c;
    int   mid;
    c.prop_gain    = GAIN_W'($urandom_range(0, 2048));
    c.integ_gain   = GAIN_W'($urandom_range(0, 512));
    c.deriv_gain   = GAIN_W'($urandom_range(0, 256));
    c.slew_step    = SERVO_W'($urandom_range(0, 3000));
    c.integ_limit  = LIMIT_W'($urandom_range(0, 100000000));
    mid            = $urandom_range(4000, 14000);
    c.servo_center = SERVO_W'(mid);
    c.servo_low    = SERVO_W'($urandom_range(0, mid));
    c.servo_high   = SERVO_W'($urandom_range(mid, 18000));
    case (style)
      CFG_ALL_MAX: begin
        c = '{prop_gain: 16'hFFFF, integ_gain: 16'hFFFF, deriv_gain: 16'hFFFF,
              slew_step: 15'd18000, integ_limit: 30'd1000000000,
              servo_center: 15'd18000, servo_low: 15'd0, servo_high: 15'd18000};
      end
      CFG_ALL_ZERO: begin
        c = '0;
      end
      CFG_CROSSED: begin
        c.servo_low  = SERVO_W'($urandom_range(9001, 18000));
        c.servo_high = SERVO_W'($urandom_range(0, 9000));
      end
      CFG_ANY: begin
        c.prop_gain    = GAIN_W'($urandom_range(0, 65535));
        c.integ_gain   = GAIN_W'($urandom_range(0, 65535));
        c.deriv_gain   = GAIN_W'($urandom_range(0, 65535));
        c.slew_step    = SERVO_W'($urandom_range(0, 18000));
        c.integ_limit  = LIMIT_W'($urandom_range(0, 1000000000));
        c.servo_center = SERVO_W'($urandom_range(0, 18000));
        c.servo_low    = SERVO_W'($urandom_range(0, 18000));
        c.servo_high   = SERVO_W'($urandom_range(0, 18000));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin : stimulus
    cfg_t c;
    int   tgt, meas, rate, dt, r;
    logic fresh, clr;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    target_heading   = '0;
    measured_heading = '0;
    yaw_rate         = '0;
    elapsed_ms       = '0;
    sample_fresh     = 1'b0;
    restart          = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero elapsed time, wrap boundaries, out-of-range headings,
    // rate extremes, stale samples and restarts.
    send_sample(0, 0, 0, 0, 1'b1, 1'b0);
    send_sample(18000, -18000, 200000, 65535, 1'b1, 1'b0);
    send_sample(-18000, 18000, -200000, 1, 1'b1, 1'b0);
    send_sample(18000, 0, 0, 10, 1'b1, 1'b0);
    send_sample(-18000, 1, 0, 10, 1'b1, 1'b0);
    send_sample(32767, -32768, 1000, 5, 1'b1, 1'b0);
    send_sample(-32768, 32767, -1000, 5, 1'b1, 1'b0);
    send_sample(100, -100, 0, 20, 1'b0, 1'b0);
    send_sample(500, 0, 3000, 20, 1'b1, 1'b1);
    send_sample(-500, 0, 0, 20, 1'b0, 1'b1);

    // Largest gains and limits: the command slams into a servo limit.
    c = '{prop_gain: 16'hFFFF, integ_gain: 16'hFFFF, deriv_gain: 16'hFFFF,
          slew_step: 15'd18000, integ_limit: 30'd1000000000,
          servo_center: 15'd9000, servo_low: 15'd0, servo_high: 15'd18000};
    load_config(c);
    send_sample(18000, 0, 0, 65535, 1'b1, 1'b0);
    send_sample(-18000, 0, 200000, 65535, 1'b1, 1'b0);
    send_sample(0, 0, -200000, 0, 1'b1, 1'b0);
    send_sample(3000, 2000, 0, 1, 1'b0, 1'b0);
    send_sample(1, 0, 0, 1, 1'b1, 1'b1);

    // Crossed limits: the high clamp wins.
    c = '{prop_gain: 16'd256, integ_gain: 16'd0, deriv_gain: 16'd0,
          slew_step: 15'd100, integ_limit: 30'd1000,
          servo_center: 15'd7100, servo_low: 15'd15000, servo_high: 15'd3000};
    load_config(c);
    send_sample(1000, 0, 0, 1, 1'b1, 1'b0);
    send_sample(-1000, 0, 0, 1, 1'b1, 1'b0);
    send_sample(0, 0, 0, 0, 1'b0, 1'b0);

    // Zero integral limit, no proportional term and a center at the bottom.
    c = '{prop_gain: 16'd0, integ_gain: 16'd1000, deriv_gain: 16'd300,
          slew_step: 15'd18000, integ_limit: 30'd0,
          servo_center: 15'd0, servo_low: 15'd0, servo_high: 15'd18000};
    load_config(c);
    send_sample(6000, 0, 50000, 100, 1'b1, 1'b0);
    send_sample(-6000, 0, -50000, 100, 1'b1, 1'b0);
    send_sample(0, 0, 0, 0, 1'b1, 1'b1);
    send_sample(17999, -1, 0, 0, 1'b1, 1'b0);

    // Random requests under a series of register settings.
    for (int p = 0; p < PHASES; p++) begin
      load_config(make_config(cfg_style_t'(p % 5)));
      // Twice the receiver holds off while requests keep coming back to back.
      if (p == 2 || p == 7) begin
        hold_reqs <= hold_reqs + 1;
        burst_left = 40;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 90) tgt = int'($urandom_range(0, 36000)) - 18000;
        else tgt = int'($urandom_range(0, 65535)) - 32768;
        r = $urandom_range(0, 99);
        if (r < 50) meas = tgt + int'($urandom_range(0, 1000)) - 500;
        else if (r < 92) meas = int'($urandom_range(0, 36000)) - 18000;
        else meas = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 9) < 6) rate = int'($urandom_range(0, 10000)) - 5000;
        else rate = int'($urandom_range(0, 400000)) - 200000;
        r = $urandom_range(0, 99);
        if (r < 10) dt = 0;
        else if (r < 80) dt = $urandom_range(1, 50);
        else dt = $urandom_range(0, 65535);
        fresh = ($urandom_range(0, 99) < 85);
        clr   = ($urandom_range(0, 99) < 3);
        send_sample(tgt, meas, rate, dt, fresh, clr);
      end
    end

    drain();
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hps_pkg.sv
hdl/hps_cfg_regs.sv
hdl/hps_ctrl.sv
hdl/hps_datapath.sv
hdl/heading_pid_steering_unit.sv
hdl/hps_checker.sv
tb/heading_pid_checker.sv
tb/tb_heading_pid_steering_unit.sv
